>>> src/prle_pkg.sv
// ----------------------------------------------------------------------------
// Pixel run-length encoder package
// Field widths, record codes, register indexes and shared structs.
// ----------------------------------------------------------------------------
package prle_pkg;

  // Payload widths
  localparam int ByteW    = 8;
  localparam int CfgW     = 11;
  localparam int CfgIdxW  = 8;
  localparam int RowIdxW  = 10;
  localparam int RunLenW  = 11;
  localparam int PixelW   = 24;
  localparam int KindW    = 2;

  // At most three records leave for one input byte
  localparam int MaxBurst = 3;

  // Record queue
  localparam int FifoDepth = 8;
  localparam int FifoPtrW  = 3;
  localparam int FifoLvlW  = 4;
  localparam int BurstCntW = 2;

  // Register reset values
  localparam logic [CfgW-1:0] RowWidthRst = 11'd480;
  localparam logic [CfgW-1:0] RowCountRst = 11'd320;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegRowWidth = 8'd0;
  localparam logic [CfgIdxW-1:0] RegRowCount = 8'd1;

  // Byte phases within a pixel; any other code is treated as blue
  localparam logic [1:0] PhaseRed   = 2'd0;
  localparam logic [1:0] PhaseGreen = 2'd1;
  localparam logic [1:0] PhaseBlue  = 2'd2;

  typedef enum logic [KindW-1:0] {
    RecRowStart = 2'd0,
    RecRun      = 2'd1,
    RecFrameEnd = 2'd2
  } rec_kind_e;

  typedef struct packed {
    rec_kind_e            record_kind;
    logic [RowIdxW-1:0]   row_index;
    logic [RunLenW-1:0]   run_length;
    logic [PixelW-1:0]    pixel_value;
    logic                 last_of_burst;
  } rec_t;

  // Records produced by one accepted byte, in order, count of them
  typedef struct packed {
    logic [BurstCntW-1:0]      count;
    rec_t [MaxBurst-1:0]       recs;
  } push_t;

  typedef struct packed {
    logic [FifoLvlW-1:0] level;
  } fifo_stat_t;

endpackage

>>> src/prle_if.sv
// ----------------------------------------------------------------------------
// Pixel run-length encoder channel interfaces
// Byte input, record output and register write channels.
// ----------------------------------------------------------------------------
interface prle_byte_if;
  logic                          valid;
  logic                          ready;
  logic [prle_pkg::ByteW-1:0]    read_byte;

  modport source(output valid, read_byte, input ready);
  modport sink(input valid, read_byte, output ready);
endinterface

interface prle_rec_if;
  logic                          valid;
  logic                          ready;
  logic [prle_pkg::KindW-1:0]    record_kind;
  logic [prle_pkg::RowIdxW-1:0]  row_index;
  logic [prle_pkg::RunLenW-1:0]  run_length;
  logic [prle_pkg::PixelW-1:0]   pixel_value;
  logic                          last_of_burst;

  modport source(output valid, record_kind, row_index, run_length, pixel_value,
                 last_of_burst, input ready);
  modport sink(input valid, record_kind, row_index, run_length, pixel_value,
               last_of_burst, output ready);
endinterface

interface prle_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [prle_pkg::CfgIdxW-1:0]  index;
  logic [prle_pkg::CfgW-1:0]     data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> src/pixel_run_length_encoder.sv
// ----------------------------------------------------------------------------
// Pixel run-length encoder top level
// Turns a display read-back byte stream into row, run and frame records.
// ----------------------------------------------------------------------------
// Accepts one byte per cycle. The first byte of a frame is dropped and opens
// row 0; following bytes form R,G,B pixels that are merged into runs within a
// row. A byte produces zero to three records (three at most on the blue byte
// that ends a row), which go into an eight-entry record queue; the byte input
// stays ready while at least three slots are free, so with the record output
// always ready the encoder sustains one byte per cycle, and records leave one
// per cycle. Register 0 is row_width and register 1 is row_count; both are
// clamped to 1..MAX_ROW_WIDTH and 1..MAX_ROW_COUNT.
module pixel_run_length_encoder #(
  parameter int MAX_ROW_WIDTH = 1024,
  parameter int MAX_ROW_COUNT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  prle_byte_if.sink   byte_i,
  prle_rec_if.source  rec_o,
  prle_cfg_if.sink    cfg_i
);
  import prle_pkg::*;

  localparam int EffW = $clog2(MAX_ROW_WIDTH + 1);
  localparam int EffC = $clog2(MAX_ROW_COUNT + 1);

  logic [EffW-1:0] eff_width;
  logic [EffC-1:0] eff_count;
  logic            in_fire;
  push_t           push;
  fifo_stat_t      fifo_stat;

  // Take a byte only when a full burst still fits in the queue
  assign byte_i.ready = fifo_stat.level <= FifoLvlW'(FifoDepth - MaxBurst);
  assign in_fire      = byte_i.valid && byte_i.ready;

  prle_cfg_regs #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH),
    .MAX_ROW_COUNT(MAX_ROW_COUNT)
  ) u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_i,
    .eff_width_o(eff_width),
    .eff_count_o(eff_count)
  );

  prle_encoder #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH),
    .MAX_ROW_COUNT(MAX_ROW_COUNT)
  ) u_enc (
    .clk_i,
    .rst_ni,
    .fire_i(in_fire),
    .read_byte_i(byte_i.read_byte),
    .eff_width_i(eff_width),
    .eff_count_i(eff_count),
    .push_o(push)
  );

  prle_rec_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i(push),
    .rec_o,
    .stat_o(fifo_stat)
  );

  // Queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.level <= FifoLvlW'(FifoDepth))
    else $error("record queue overflow");

  // An empty queue with no byte taken shows no record next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_stat.level == '0 && !in_fire) |=> !rec_o.valid)
    else $error("record appeared without an input byte");

  // No records are pushed without an accepted byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |-> push.count == '0)
    else $error("records pushed without an accepted byte");

endmodule

>>> src/prle_cfg_regs.sv
// ----------------------------------------------------------------------------
// Pixel run-length encoder configuration registers
// Holds row width and row count and clamps them to their usable range.
// ----------------------------------------------------------------------------
module prle_cfg_regs #(
  parameter int MAX_ROW_WIDTH = 1024,
  parameter int MAX_ROW_COUNT = 1024,
  localparam int EffW = $clog2(MAX_ROW_WIDTH + 1),
  localparam int EffC = $clog2(MAX_ROW_COUNT + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  prle_cfg_if.sink        cfg_i,
  output logic [EffW-1:0] eff_width_o,
  output logic [EffC-1:0] eff_count_o
);
  import prle_pkg::*;

  logic [CfgW-1:0] row_width_q;
  logic [CfgW-1:0] row_count_q;

  // Always take register writes
  assign cfg_i.ready = 1'b1;

  // Write a register; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= RowWidthRst;
      row_count_q <= RowCountRst;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == RegRowWidth) begin
        row_width_q <= cfg_i.data;
      end else if (cfg_i.index == RegRowCount) begin
        row_count_q <= cfg_i.data;
      end
    end
  end

  // Clamp width to 1..MAX_ROW_WIDTH
  always_comb begin
    if (row_width_q == '0) begin
      eff_width_o = EffW'(1);
    end else if (32'(row_width_q) > 32'(MAX_ROW_WIDTH)) begin
      eff_width_o = EffW'(MAX_ROW_WIDTH);
    end else begin
      eff_width_o = EffW'(row_width_q);
    end
  end

  // Clamp count to 1..MAX_ROW_COUNT
  always_comb begin
    if (row_count_q == '0) begin
      eff_count_o = EffC'(1);
    end else if (32'(row_count_q) > 32'(MAX_ROW_COUNT)) begin
      eff_count_o = EffC'(MAX_ROW_COUNT);
    end else begin
      eff_count_o = EffC'(row_count_q);
    end
  end

endmodule

>>> src/prle_encoder.sv
// ----------------------------------------------------------------------------
// Pixel run-length encoder core
// Assembles pixels from bytes, tracks runs and row position, forms records.
// ----------------------------------------------------------------------------
module prle_encoder #(
  parameter int MAX_ROW_WIDTH = 1024,
  parameter int MAX_ROW_COUNT = 1024,
  localparam int EffW = $clog2(MAX_ROW_WIDTH + 1),
  localparam int EffC = $clog2(MAX_ROW_COUNT + 1),
  localparam int ColW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1,
  localparam int RowW = (MAX_ROW_COUNT > 1) ? $clog2(MAX_ROW_COUNT) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [prle_pkg::ByteW-1:0]    read_byte_i,
  input  logic [EffW-1:0]               eff_width_i,
  input  logic [EffC-1:0]               eff_count_i,
  output prle_pkg::push_t               push_o
);
  import prle_pkg::*;

  logic              junk_pending_q, junk_pending_d;
  logic [1:0]        byte_phase_q, byte_phase_d;
  logic [ByteW-1:0]  red_hold_q, red_hold_d;
  logic [ByteW-1:0]  green_hold_q, green_hold_d;
  logic [ColW-1:0]   column_pos_q, column_pos_d;
  logic [RowW-1:0]   row_pos_q, row_pos_d;
  logic [EffW-1:0]   run_count_q, run_count_d;
  logic [PixelW-1:0] run_colour_q, run_colour_d;

  logic [PixelW-1:0]    pixel;
  logic [EffW-1:0]      col_next;
  logic [EffC-1:0]      row_next;
  logic                 row_end;
  logic                 frame_end;
  logic [BurstCntW-1:0] n;
  rec_t [MaxBurst-1:0]  recs;

  function automatic rec_t mk_rec(rec_kind_e kind, logic [RowIdxW-1:0] row,
                                  logic [RunLenW-1:0] len, logic [PixelW-1:0] pix);
    rec_t r;
    r.record_kind   = kind;
    r.row_index     = row;
    r.run_length    = len;
    r.pixel_value   = pix;
    r.last_of_burst = 1'b0;
    return r;
  endfunction

  assign pixel     = {red_hold_q, green_hold_q, read_byte_i};
  assign col_next  = EffW'(column_pos_q) + EffW'(1);
  assign row_next  = EffC'(row_pos_q) + EffC'(1);
  assign row_end   = col_next >= eff_width_i;
  assign frame_end = row_next >= eff_count_i;

  // Next state and records for the byte on the input
  always_comb begin
    junk_pending_d = junk_pending_q;
    byte_phase_d   = byte_phase_q;
    red_hold_d     = red_hold_q;
    green_hold_d   = green_hold_q;
    column_pos_d   = column_pos_q;
    row_pos_d      = row_pos_q;
    run_count_d    = run_count_q;
    run_colour_d   = run_colour_q;
    n              = '0;
    recs           = '0;

    if (junk_pending_q) begin
      // Drop the junk byte and open row 0
      junk_pending_d = 1'b0;
      byte_phase_d   = PhaseRed;
      column_pos_d   = '0;
      row_pos_d      = '0;
      run_count_d    = '0;
      recs[0] = mk_rec(RecRowStart, '0, RunLenW'(eff_width_i), '0);
      n = BurstCntW'(1);
    end else if (byte_phase_q == PhaseRed) begin
      red_hold_d   = read_byte_i;
      byte_phase_d = PhaseGreen;
    end else if (byte_phase_q == PhaseGreen) begin
      green_hold_d = read_byte_i;
      byte_phase_d = PhaseBlue;
    end else begin
      byte_phase_d = PhaseRed;
      // Extend the open run or close it on a colour change
      if (run_count_q == '0) begin
        run_count_d  = EffW'(1);
        run_colour_d = pixel;
      end else if (pixel == run_colour_q) begin
        run_count_d = run_count_q + EffW'(1);
      end else begin
        recs[n] = mk_rec(RecRun, RowIdxW'(row_pos_q), RunLenW'(run_count_q),
                         run_colour_q);
        n = n + BurstCntW'(1);
        run_count_d  = EffW'(1);
        run_colour_d = pixel;
      end
      // Close the row: final run, then next row start or frame end
      if (row_end) begin
        recs[n] = mk_rec(RecRun, RowIdxW'(row_pos_q), RunLenW'(run_count_d),
                         run_colour_d);
        n = n + BurstCntW'(1);
        run_count_d  = '0;
        column_pos_d = '0;
        if (frame_end) begin
          recs[n] = mk_rec(RecFrameEnd, RowIdxW'(eff_count_i - EffC'(1)), '0, '0);
          n = n + BurstCntW'(1);
          row_pos_d      = '0;
          junk_pending_d = 1'b1;
        end else begin
          row_pos_d = RowW'(row_next);
          recs[n] = mk_rec(RecRowStart, RowIdxW'(row_next), RunLenW'(eff_width_i),
                           '0);
          n = n + BurstCntW'(1);
        end
      end else begin
        column_pos_d = ColW'(col_next);
      end
    end

    // Mark the last record of the burst
    if (n != '0) begin
      recs[n - BurstCntW'(1)].last_of_burst = 1'b1;
    end
  end

  // Hand records to the queue only for an accepted byte
  always_comb begin
    push_o.recs  = recs;
    push_o.count = fire_i ? n : '0;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      junk_pending_q <= 1'b1;
      byte_phase_q   <= PhaseRed;
      red_hold_q     <= '0;
      green_hold_q   <= '0;
      column_pos_q   <= '0;
      row_pos_q      <= '0;
      run_count_q    <= '0;
      run_colour_q   <= '0;
    end else if (fire_i) begin
      junk_pending_q <= junk_pending_d;
      byte_phase_q   <= byte_phase_d;
      red_hold_q     <= red_hold_d;
      green_hold_q   <= green_hold_d;
      column_pos_q   <= column_pos_d;
      row_pos_q      <= row_pos_d;
      run_count_q    <= run_count_d;
      run_colour_q   <= run_colour_d;
    end
  end

endmodule

>>> src/prle_rec_fifo.sv
// ----------------------------------------------------------------------------
// Pixel run-length encoder record queue
// Takes up to three records per cycle and presents one per transaction.
// ----------------------------------------------------------------------------
module prle_rec_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  prle_pkg::push_t       push_i,
  prle_rec_if.source            rec_o,
  output prle_pkg::fifo_stat_t  stat_o
);
  import prle_pkg::*;

  rec_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoLvlW-1:0] level_q, level_d;
  logic                pop;
  rec_t                head;

  assign head = mem_q[rd_ptr_q];
  assign pop  = rec_o.valid && rec_o.ready;

  // Present the oldest record
  assign rec_o.valid         = level_q != '0;
  assign rec_o.record_kind   = head.record_kind;
  assign rec_o.row_index     = head.row_index;
  assign rec_o.run_length    = head.run_length;
  assign rec_o.pixel_value   = head.pixel_value;
  assign rec_o.last_of_burst = head.last_of_burst;
  assign stat_o.level        = level_q;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q + FifoPtrW'(push_i.count);
    rd_ptr_d = rd_ptr_q + FifoPtrW'(pop);
    level_d  = level_q + FifoLvlW'(push_i.count) - FifoLvlW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // Store the burst at consecutive slots
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxBurst; i++) begin
      if (BurstCntW'(i) < push_i.count) begin
        mem_q[wr_ptr_q + FifoPtrW'(i)] <= push_i.recs[i];
      end
    end
  end

endmodule
